// ----- sv/ccrd_pkg.sv -----
package ccrd_pkg;

  // coordinate math: 12-bit fields plus a 12-bit extent fit in 14 signed bits
  localparam int CRD_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 7;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

  localparam logic [COLS_W-1:0] COLS_RST = 8'd128;
  localparam logic [ROWS_W-1:0] ROWS_RST = 7'd64;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_GET   = 2'd1,
    MODE_RECT  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [7:0]         char_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       in_bounds;
  } out_item_t;

  // index width for a dimension of n cells (at least one bit)
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- sv/ccrd_in_if.sv -----
interface ccrd_in_if;
  import ccrd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ccrd_out_if.sv -----
interface ccrd_out_if;
  import ccrd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ccrd_mem.sv -----
module ccrd_mem #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// ----- sv/ccrd_seq.sv -----
module ccrd_seq #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int CW       = 7,
  parameter int RW       = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ccrd_pkg::in_item_t        in_item,
  input  logic [ccrd_pkg::COLS_W-1:0] cols_cfg,
  input  logic [ccrd_pkg::ROWS_W-1:0] rows_cfg,
  output logic                      res_valid,
  input  logic                      res_ready,
  output ccrd_pkg::out_item_t       res_item,
  output logic                      mem_we,
  output logic                      mem_re,
  output logic [CW+RW-1:0]          mem_addr,
  output logic [7:0]                mem_wdata,
  input  logic [7:0]                mem_rdata
);
  import ccrd_pkg::*;

  localparam int AW = CW + RW;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] init_addr_r, init_addr_nxt;

  mode_t         mode_r;
  logic          ok_r;
  logic [7:0]    ch_r;
  logic          full_all_r;
  logic          empty_r;
  crd_t          x_r, y_r, xe_r, ye_r;
  logic [RW-1:0] row_r, r1_r;
  logic [CW-1:0] col_r, c0_r, c1_r;
  logic          left_ok_r, right_ok_r, side_r;

  // canvas size clamped to the store
  crd_t nc, nr, ncm1, nrm1;
  crd_t px, py, pw, ph;
  logic pt_in;
  crd_t c0, c1, r0, r1;
  logic box_empty;

  logic          row_full, last_col, last_row;
  logic [RW-1:0] row_nxt;
  logic [CW-1:0] col_nxt;
  logic          side_nxt;

  always_comb begin
    nc = (CRD_W'(cols_cfg) > CRD_W'(MAX_COLS)) ? crd_t'(MAX_COLS) : crd_t'(cols_cfg);
    nr = (CRD_W'(rows_cfg) > CRD_W'(MAX_ROWS)) ? crd_t'(MAX_ROWS) : crd_t'(rows_cfg);
    ncm1 = nc - crd_t'(1);
    nrm1 = nr - crd_t'(1);
    px = crd_t'(in_item.pos_x);
    py = crd_t'(in_item.pos_y);
    pw = crd_t'(in_item.rect_width);
    ph = crd_t'(in_item.rect_height);
    pt_in = (px >= 0) && (py >= 0) && (px < nc) && (py < nr);
    // clipped box
    c0 = (x_r < 0) ? '0 : x_r;
    r0 = (y_r < 0) ? '0 : y_r;
    c1 = (xe_r > ncm1) ? ncm1 : xe_r;
    r1 = (ye_r > nrm1) ? nrm1 : ye_r;
    box_empty = empty_r || (c0 > c1) || (r0 > r1);
  end

  // walk: top/bottom rows (every row for a clear) sweep every clipped column, other rows hit both ends
  always_comb begin
    row_full = full_all_r || (crd_t'(row_r) == y_r) || (crd_t'(row_r) == ye_r);
    last_col = row_full ? (col_r == c1_r) : side_r;
    last_row = (row_r == r1_r);
    row_nxt  = row_r;
    col_nxt  = col_r;
    side_nxt = side_r;
    if (last_col) begin
      row_nxt  = row_r + RW'(1);
      col_nxt  = c0_r;
      side_nxt = 1'b0;
    end else if (row_full) begin
      col_nxt = col_r + CW'(1);
    end else begin
      side_nxt = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = ch_r;
    case (state_r)
      ST_INIT: begin
        mem_we        = 1'b1;
        mem_addr      = init_addr_r;
        mem_wdata     = SPACE_CHAR;
        init_addr_nxt = init_addr_r + AW'(1);
        if (&init_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        mem_addr  = {py[RW-1:0], px[CW-1:0]};
        mem_wdata = in_item.char_value;
        if (in_valid) begin
          case (in_item.mode)
            MODE_SET: begin
              mem_we    = pt_in;
              state_nxt = ST_RESP;
            end
            MODE_GET: begin
              mem_re    = pt_in;
              state_nxt = ST_RESP;
            end
            MODE_RECT, MODE_CLEAR: state_nxt = ST_SETUP;
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SETUP: begin
        state_nxt = box_empty ? ST_RESP : ST_RUN;
      end
      ST_RUN: begin
        mem_we = row_full || (side_r ? right_ok_r : left_ok_r);
        if (row_full) begin
          mem_addr = {row_r, col_r};
        end else if (side_r) begin
          mem_addr = {row_r, xe_r[CW-1:0]};
        end else begin
          mem_addr = {row_r, x_r[CW-1:0]};
        end
        if (last_col && last_row) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      mode_r     <= in_item.mode;
      ok_r       <= pt_in && (in_item.mode == MODE_SET || in_item.mode == MODE_GET);
      full_all_r <= (in_item.mode == MODE_CLEAR);
      // clear never counts as empty; a rect does with zero width or height
      empty_r    <= (in_item.mode != MODE_CLEAR) &&
                    ((in_item.rect_width == '0) || (in_item.rect_height == '0));
      if (in_item.mode == MODE_CLEAR) begin
        ch_r    <= SPACE_CHAR;
        x_r     <= '0;
        y_r     <= '0;
        xe_r    <= ncm1;
        ye_r    <= nrm1;
      end else begin
        ch_r <= in_item.char_value;
        x_r  <= px;
        y_r  <= py;
        xe_r <= px + pw - crd_t'(1);
        ye_r <= py + ph - crd_t'(1);
      end
    end
    if (state_r == ST_SETUP) begin
      row_r      <= r0[RW-1:0];
      col_r      <= c0[CW-1:0];
      c0_r       <= c0[CW-1:0];
      c1_r       <= c1[CW-1:0];
      r1_r       <= r1[RW-1:0];
      left_ok_r  <= (x_r >= 0) && (x_r <= c1);
      right_ok_r <= (xe_r >= 0) && (xe_r <= c1);
      side_r     <= 1'b0;
    end
    if (state_r == ST_RUN) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      side_r <= side_nxt;
    end
  end

  always_comb begin
    res_item.in_bounds = ok_r;
    res_item.read_char = '0;
    if (mode_r == MODE_GET) begin
      res_item.read_char = ok_r ? mem_rdata : SPACE_CHAR;
    end
  end
endmodule

// ----- sv/char_canvas_rect_draw.sv -----
// channel | dir | handshake          | item
// --------+-----+--------------------+----------------------------------------------
// in_ch   | in  | valid/ready        | mode, pos_x, pos_y, rect_width/height, char
// out_ch  | out | valid/ready        | read_char, in_bounds (one per input item)
// cfg_*   | in  | cfg_we, no stall   | index 0 canvas_cols, 1 canvas_rows
//
// Set point and get point go from acceptance to the result state (get point reads the
// frame memory on acceptance). Draw rect clips the box in a setup state, then visits
// each cell of the top and bottom rows and both edges of each middle row; clear visits
// every cell of the canvas, one at a time through the frame memory's single write port.
// After reset a clearing pass writes spaces to all 2**(CW+RW) entries while
// in_ch.ready stays low; cfg writes are taken throughout.
// A result waits in the output register; the next item is accepted meanwhile.
module char_canvas_rect_draw #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ccrd_in_if.sink                       in_ch,
  ccrd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ccrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccrd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ccrd_pkg::*;

  // address = {row, col}: column field sized to the store width
  localparam int CW = idx_w(MAX_COLS);
  localparam int RW = idx_w(MAX_ROWS);
  localparam int AW = CW + RW;

  // canvas size registers
  logic [COLS_W-1:0] cols_r;
  logic [ROWS_W-1:0] rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RST;
      rows_r <= ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_r <= cfg_wdata[COLS_W-1:0];
        CFG_ROWS: rows_r <= cfg_wdata[ROWS_W-1:0];
        default: ; // index beyond the list: ignored
      endcase
    end
  end

  // frame memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  // sequencer result
  logic      res_valid, res_ready;
  out_item_t res_item;

  ccrd_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW),
    .RW       (RW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.data),
    .cols_cfg  (cols_r),
    .rows_cfg  (rows_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  ccrd_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  logic      out_valid_r;
  out_item_t out_item_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;
endmodule

// ----- test/ccrd_reply_checker.sv -----
module ccrd_reply_checker #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ccrd_in_if                              in_ch,
  ccrd_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [ccrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccrd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ccrd_pkg::*;

  localparam int REPORT_MAX = 10;

  // shadow copy of the frame memory and the canvas size
  logic [7:0]        cells [MAX_ROWS][MAX_COLS];
  logic [COLS_W-1:0] cols_reg;
  logic [ROWS_W-1:0] rows_reg;
  out_item_t         reply_q [$];
  int                errors = 0;

  function automatic int used_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int used_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  // applies one item to the shadow canvas, returns the reply it causes
  function automatic out_item_t run_canvas_op(input in_item_t it);
    out_item_t rsp;
    int x, y, w, h, xe, ye, nc, nr;
    bit hit;
    x  = $signed(it.pos_x);
    y  = $signed(it.pos_y);
    w  = it.rect_width;
    h  = it.rect_height;
    nc = used_cols();
    nr = used_rows();
    hit = x >= 0 && y >= 0 && x < nc && y < nr;
    rsp = '0;
    case (it.mode)
      MODE_SET: begin
        if (hit) begin
          cells[y][x]   = it.char_value;
          rsp.in_bounds = 1'b1;
        end
      end
      MODE_GET: begin
        if (hit) begin
          rsp.read_char = cells[y][x];
          rsp.in_bounds = 1'b1;
        end else begin
          rsp.read_char = SPACE_CHAR;
        end
      end
      MODE_RECT: begin
        if (w > 0 && h > 0) begin
          xe = x + w - 1;
          ye = y + h - 1;
          // walk the clipped box, write only the outline
          for (int r = (y > 0) ? y : 0; r <= ye && r < nr; r++)
            for (int c = (x > 0) ? x : 0; c <= xe && c < nc; c++)
              if (c == x || c == xe || r == y || r == ye) cells[r][c] = it.char_value;
        end
      end
      MODE_CLEAR: begin
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++)
            cells[r][c] = SPACE_CHAR;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (cells[r, c]) cells[r][c] = SPACE_CHAR;
      cols_reg = COLS_RST;
      rows_reg = ROWS_RST;
      reply_q.delete();
    end else begin
      // a reply at this edge always belongs to an earlier item
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected reply read_char %h in_bounds %b",
                     $realtime, out_ch.data.read_char, out_ch.data.in_bounds);
        end else begin
          want = reply_q.pop_front();
          if (out_ch.data.read_char !== want.read_char ||
              out_ch.data.in_bounds !== want.in_bounds) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: reply mismatch: read_char exp %h got %h, in_bounds exp %b got %b",
                       $realtime, want.read_char, out_ch.data.read_char,
                       want.in_bounds, out_ch.data.in_bounds);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) reply_q.push_back(run_canvas_op(in_ch.data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_COLS: cols_reg = cfg_wdata[COLS_W-1:0];
          CFG_ROWS: rows_reg = cfg_wdata[ROWS_W-1:0];
          default: ;
        endcase
      end
    end
    pending    <= reply_q.size();
    fail_count <= errors;
  end

endmodule

// ----- test/char_canvas_rect_draw_test.sv -----
module char_canvas_rect_draw_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccrd_pkg::*;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;

  // register indexes past the end of the list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // worst case here is a clear of the full canvas plus the post-reset clearing pass
  localparam int RUN_LIMIT       = 5_000_000;
  localparam int TAIL_CYCLES     = 16;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int NUM_PHASES      = 12;

  // canvas sizes per random phase: oversize, one cell, empty, full, odd sizes
  localparam logic [7:0] PHASE_COLS [NUM_PHASES] = '{
    8'd255, 8'd1, 8'd0, 8'd128, 8'd7, 8'd200, 8'd33, 8'd128, 8'd16, 8'd0, 8'd64, 8'd128};
  localparam logic [7:0] PHASE_ROWS [NUM_PHASES] = '{
    8'd255, 8'd1, 8'd0, 8'd64, 8'd5, 8'd100, 8'd17, 8'd200, 8'd8, 8'd40, 8'd32, 8'd64};

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int cycle_count;

  // idle controls: percent of cycles the sender holds off / receiver stalls
  int gap_pct   = 0;
  int stall_pct = 0;

  // canvas size as the block sees it, for aiming coordinates
  int cols_used = MAX_COLS;
  int rows_used = MAX_ROWS;
  int last_x    = 0;
  int last_y    = 0;

  ccrd_in_if  in_ch ();
  ccrd_out_if out_ch ();

  char_canvas_rect_draw #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ccrd_reply_checker #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: one ready decision per edge
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Send one item. Valid is left high after acceptance; the next call (or
  // drain) decides in the same step whether it drops or carries new data,
  // so valid never sees two assignments in one step.
  task automatic issue(input mode_t op, input int x, input int y,
                       input int w, input int h, input logic [7:0] ch);
    in_item_t it;
    it.mode        = op;
    it.pos_x       = 12'(x);
    it.pos_y       = 12'(y);
    it.rect_width  = 12'(w);
    it.rect_height = 12'(h);
    it.char_value  = ch;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // hold off until every reply is back; pending is registered, hence
  // the edge before the first look
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // only called with the block idle; also pokes the unused indexes
  task automatic set_canvas(input logic [7:0] cols, input logic [7:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CFG_SPARE_2;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= CFG_SPARE_3;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cols_used = (cols > MAX_COLS) ? MAX_COLS : int'(cols);
    rows_used = (rows[6:0] > MAX_ROWS) ? MAX_ROWS : int'(rows[6:0]);
  endtask

  // mostly on or just around the canvas, sometimes anywhere in 12 bits
  function automatic int pick_coord(input int span);
    if ($urandom_range(99) < 80) return int'($urandom_range(span + 3)) - 2;
    return int'($urandom_range(4095)) - 2048;
  endfunction

  function automatic int pick_extent(input int span);
    if ($urandom_range(99) < 85) return $urandom_range(span + 2);
    return $urandom_range(2048);
  endfunction

  initial begin
    int roll;
    int x, y;
    mode_t op;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_COLS;
    cfg_wdata    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, default 128x64 canvas ----
    // corners, all-ones and all-zero characters
    issue(MODE_SET, 0, 0, 0, 0, 8'hFF);
    issue(MODE_GET, 0, 0, 2048, 2048, 8'h00);
    issue(MODE_SET, 127, 63, 4095, 4095, 8'h00);
    issue(MODE_GET, 127, 63, 0, 0, 8'hFF);
    // just past the edges and the coordinate extremes: not in bounds
    issue(MODE_SET, 128, 0, 0, 0, 8'h41);
    issue(MODE_SET, 0, 64, 0, 0, 8'h41);
    issue(MODE_SET, -2048, 2047, 0, 0, 8'h41);
    issue(MODE_GET, 2047, -2048, 0, 0, 8'h00);
    issue(MODE_GET, -1, 0, 0, 0, 8'h00);
    // plain outline, then one cell on it and one inside it
    issue(MODE_RECT, 10, 10, 20, 5, 8'h23);
    issue(MODE_GET, 10, 12, 0, 0, 8'h00);
    issue(MODE_GET, 15, 12, 0, 0, 8'h00);
    // zero width or height writes nothing
    issue(MODE_RECT, 0, 0, 0, 5, 8'h5A);
    issue(MODE_RECT, 0, 0, 5, 0, 8'h5A);
    issue(MODE_GET, 0, 0, 0, 0, 8'h00);
    // wholly off canvas, clipped on two sides, single cell, clipped far side
    issue(MODE_RECT, -2048, -2048, 2048, 2048, 8'h2A);
    issue(MODE_RECT, -3, -2, 10, 6, 8'h2B);
    issue(MODE_RECT, 1, 1, 1, 1, 8'h2C);
    issue(MODE_RECT, 120, 60, 2048, 2048, 8'h2D);
    issue(MODE_SET, 100, 50, 0, 0, 8'hA5);

    // shrink: cells beyond the canvas must survive clear and rect
    drain();
    set_canvas(8'd8, 8'd4);
    issue(MODE_CLEAR, 0, 0, 0, 0, 8'h00);
    issue(MODE_GET, 100, 50, 0, 0, 8'h00);
    issue(MODE_RECT, 0, 0, 8, 4, 8'h7E);
    drain();
    set_canvas(8'd128, 8'd64);
    issue(MODE_GET, 100, 50, 0, 0, 8'h00);
    issue(MODE_GET, 10, 10, 0, 0, 8'h00);
    issue(MODE_CLEAR, 0, 0, 0, 0, 8'h00);
    issue(MODE_GET, 127, 63, 0, 0, 8'h00);

    // ---- random phases ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_canvas(PHASE_COLS[p], PHASE_ROWS[p]);
      // rotate: no idling, sender idle, receiver stalls, both
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 56; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 56; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // now and then let the pipe run dry before the next item
        if ($urandom_range(49) == 0) drain();
        roll = $urandom_range(99);
        if (roll < 38)      op = MODE_SET;
        else if (roll < 76) op = MODE_GET;
        else if (roll < 97) op = MODE_RECT;
        else                op = MODE_CLEAR;
        x = pick_coord(cols_used);
        y = pick_coord(rows_used);
        // gets often revisit the last written spot so writes get read back
        if (op == MODE_GET && $urandom_range(99) < 40) begin
          x = last_x;
          y = last_y;
        end
        if (op == MODE_SET || op == MODE_RECT) begin
          last_x = x;
          last_y = y;
        end
        issue(op, x, y, pick_extent(cols_used), pick_extent(rows_used),
              8'($urandom_range(255)));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
